// ----- rtl/nearest_palette_index_select_unit_defines.svh -----
// Assertion macros shared by the palette search RTL.
// Needs clk and arst_n in the scope of each use; no other dependencies.
`ifndef NEAREST_PALETTE_INDEX_SELECT_UNIT_DEFINES_SVH
`define NEAREST_PALETTE_INDEX_SELECT_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NPIS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NPIS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/npis_pkg.sv -----
// Shared types and constants for the nearest palette index search.
// No dependencies; imported by every module of the block.
package npis_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int IDX_W = $clog2(PALETTE_DEPTH);
	localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
	localparam int DIST_CEILING = 256 * 256 * 3;
	localparam int DIST_W = $clog2(DIST_CEILING + 1);
	localparam int COLOR_W = 8;
	localparam int NUM_W = 9;
	localparam int OUT_W = 9;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_SELECT = 1'b1
	} cmd_code_t;

	typedef enum logic {
		REG_NUM_ENTRIES = 1'b0,
		REG_INDEX_OFFSET = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic wr_en;
		logic start;
		logic rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic rd_last;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
	} dp_status_t;

endpackage

// ----- rtl/npis_datapath.sv -----
// Datapath: palette memory, distance pipeline, running minimum and output word.
// Depends on npis_pkg; driven by npis_ctrl through dp_cmd_t.
module npis_datapath import npis_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	input  logic [7:0]         entry_index,
	input  logic [COLOR_W-1:0] red,
	input  logic [COLOR_W-1:0] green,
	input  logic [COLOR_W-1:0] blue,
	input  logic [7:0]         index_offset,
	output logic [OUT_W-1:0]   color_index
);

	logic [3*COLOR_W-1:0] mem [PALETTE_DEPTH];

	logic [COLOR_W-1:0] qr_q, qg_q, qb_q;
	logic [3*COLOR_W-1:0] entry_s1;
	logic valid_s1, last_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [2*COLOR_W-1:0] sq_r_s2, sq_g_s2, sq_b_s2;
	logic valid_s2, last_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [DIST_W-1:0] best_dist_q;
	logic [IDX_W-1:0] best_idx_q;
	logic done_q;
	logic [OUT_W-1:0] color_index_q;

	logic [COLOR_W-1:0] dr, dg, db;
	logic [DIST_W-1:0] dist_sum;
	logic wr_ok;

	assign wr_ok = 9'(entry_index) < 9'(PALETTE_DEPTH);

	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_ok) begin
			mem[entry_index[IDX_W-1:0]] <= {red, green, blue};
		end
		if (cmd.rd_en) begin
			entry_s1 <= mem[cmd.rd_addr];
		end
	end

	always_comb begin
		dr = (qr_q >= entry_s1[23:16]) ? qr_q - entry_s1[23:16] : entry_s1[23:16] - qr_q;
		dg = (qg_q >= entry_s1[15:8]) ? qg_q - entry_s1[15:8] : entry_s1[15:8] - qg_q;
		db = (qb_q >= entry_s1[7:0]) ? qb_q - entry_s1[7:0] : entry_s1[7:0] - qb_q;
		dist_sum = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			valid_s2 <= valid_s1;
			done_q <= valid_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qr_q <= red;
			qg_q <= green;
			qb_q <= blue;
		end
		idx_s1 <= cmd.rd_addr;
		last_s1 <= cmd.rd_last;
		idx_s2 <= idx_s1;
		last_s2 <= last_s1;
		sq_r_s2 <= (2*COLOR_W)'(dr) * (2*COLOR_W)'(dr);
		sq_g_s2 <= (2*COLOR_W)'(dg) * (2*COLOR_W)'(dg);
		sq_b_s2 <= (2*COLOR_W)'(db) * (2*COLOR_W)'(db);
		if (cmd.start) begin
			best_dist_q <= DIST_W'(DIST_CEILING);
			best_idx_q <= '0;
		end else if (valid_s2 && (dist_sum < best_dist_q)) begin
			best_dist_q <= dist_sum;
			best_idx_q <= idx_s2;
		end
		if (cmd.load_out) begin
			color_index_q <= OUT_W'(best_idx_q) + OUT_W'(index_offset);
		end
	end

	assign status.done = done_q;
	assign color_index = color_index_q;

endmodule

// ----- rtl/npis_ctrl.sv -----
// Controller state machine: input handshake, scan sequencing and output word valid.
// Depends on npis_pkg and the assertion macro header.
`include "nearest_palette_index_select_unit_defines.svh"

module npis_ctrl import npis_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             in_cmd,
	input  logic [CNT_W-1:0] active_count,
	output logic             out_valid,
	input  logic             out_stall,
	output dp_cmd_t          cmd,
	input  dp_status_t       status
);

	state_t state_q, state_d;
	logic [IDX_W-1:0] cnt_q;
	logic out_valid_q;
	logic accept, out_free, last;

	assign accept = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign last = CNT_W'(cnt_q) == (active_count - CNT_W'(1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (in_cmd == CMD_SELECT)) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (last) state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (status.done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = state_q != ST_IDLE;
		cmd.wr_en = accept && (in_cmd == CMD_LOAD);
		cmd.start = accept && (in_cmd == CMD_SELECT);
		cmd.rd_en = state_q == ST_SCAN;
		cmd.rd_addr = cnt_q;
		cmd.rd_last = last;
		cmd.load_out = (state_q == ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q != ST_SCAN) cnt_q <= '0;
			else cnt_q <= cnt_q + IDX_W'(1);
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`NPIS_ASSERT_NOW(a_scan_in_range, state_q == ST_SCAN,
		CNT_W'(cnt_q) < active_count, "scan address beyond active entries")
	`NPIS_ASSERT_NOW(a_load_out_free, cmd.load_out,
		!out_valid_q || !out_stall, "output word overwritten while stalled")
	`NPIS_ASSERT_NOW(a_done_in_wait, status.done,
		state_q == ST_WAIT, "search done outside wait state")
	`NPIS_ASSERT_NEXT(a_select_scans, cmd.start,
		state_q == ST_SCAN && cnt_q == '0, "select did not start a scan at entry zero")

endmodule

// ----- rtl/nearest_palette_index_select_unit.sv -----
// Top level of the nearest palette index search: configuration registers and wiring.
// Depends on npis_pkg, npis_ctrl and npis_datapath.
//
// Channel   Direction  Handshake             Words
// input     in         in_valid / in_stall   cmd, entry_index, red, green, blue
// output    out        out_valid / out_stall color_index
// config    in         cfg_write             cfg_index, cfg_data
//
// A load word writes its entry with no scan. A select word scans the n active
// entries through the one memory read port, one entry per cycle.
// Reset leaves num_entries at 256 and index_offset at 0; palette contents are unknown.
// A finished result waits in the output register while out_stall is high; loads are
// still taken then, and a further select stalls only at its final step.
module nearest_palette_index_select_unit import npis_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [7:0]         entry_index,
	input  logic [COLOR_W-1:0] red,
	input  logic [COLOR_W-1:0] green,
	input  logic [COLOR_W-1:0] blue,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [OUT_W-1:0]   color_index,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [NUM_W-1:0]   cfg_data
);

	logic [NUM_W-1:0] num_entries_q;
	logic [7:0] index_offset_q;
	logic [CNT_W-1:0] active_count;
	dp_cmd_t dp_cmd;
	dp_status_t dp_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_entries_q <= NUM_W'(256);
			index_offset_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_NUM_ENTRIES: num_entries_q <= cfg_data;
				REG_INDEX_OFFSET: index_offset_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Zero entries searches entry zero; counts past the depth saturate.
	always_comb begin
		if (num_entries_q == '0) active_count = CNT_W'(1);
		else if (num_entries_q > NUM_W'(PALETTE_DEPTH)) active_count = CNT_W'(PALETTE_DEPTH);
		else active_count = CNT_W'(num_entries_q);
	end

	npis_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_cmd       (cmd),
		.active_count (active_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cmd          (dp_cmd),
		.status       (dp_status)
	);

	npis_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.status       (dp_status),
		.entry_index  (entry_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.index_offset (index_offset_q),
		.color_index  (color_index)
	);

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for nearest_palette_index_select_unit: loads palettes, runs
// color searches under random idling and stalls, and checks every color_index word.
// Depends on npis_pkg and the block's RTL only.
module tb;
	import npis_pkg::*;

	typedef struct {
		cmd_code_t op;
		logic [7:0] slot;
		logic [COLOR_W-1:0] r;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] b;
	} palette_word_t;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int PHASES = 12;
	localparam int PHASE_WORDS = 45;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = 1'b0;
	logic [7:0] entry_index = '0;
	logic [COLOR_W-1:0] red = '0;
	logic [COLOR_W-1:0] green = '0;
	logic [COLOR_W-1:0] blue = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [OUT_W-1:0] color_index;
	logic cfg_write = 1'b0;
	logic cfg_index = 1'b0;
	logic [NUM_W-1:0] cfg_data = '0;

	palette_word_t word_q[$];
	palette_word_t cur_word;
	logic [OUT_W-1:0] index_q[$];
	logic [OUT_W-1:0] want_index;
	logic [COLOR_W-1:0] pal_r[PALETTE_DEPTH];
	logic [COLOR_W-1:0] pal_g[PALETTE_DEPTH];
	logic [COLOR_W-1:0] pal_b[PALETTE_DEPTH];
	logic [NUM_W-1:0] num_cfg = 9'd256;
	logic [7:0] offset_cfg = 8'd0;
	bit drv_busy = 1'b0;
	bit drv_calm = 1'b0;
	int drv_gap = 0;
	bit rx_calm = 1'b0;
	int rx_wait = 0;
	int err_count = 0;
	int cycles = 0;

	int ph_num[PHASES] = '{1, 0, 2, 256, 511, 257, 17, 255, 128, 64, 200, 3};
	int ph_off[PHASES] = '{255, 427, 0, 255, 1, 128, 300, 77, 511, 0, 200, 33};

	nearest_palette_index_select_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.entry_index(entry_index),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.color_index(color_index),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int active_count();
		int n;
		n = num_cfg;
		if (n == 0)
			n = 1;
		if (n > PALETTE_DEPTH)
			n = PALETTE_DEPTH;
		return n;
	endfunction

	function automatic logic [OUT_W-1:0] nearest_color(input logic [COLOR_W-1:0] r,
			input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
		int n, best, best_d, d, dr, dg, db;
		n = active_count();
		best = 0;
		best_d = DIST_CEILING;
		for (int i = 0; i < n; i++) begin
			dr = int'(r) - int'(pal_r[i]);
			dg = int'(g) - int'(pal_g[i]);
			db = int'(b) - int'(pal_b[i]);
			d = dr * dr + dg * dg + db * db;
			if (d < best_d) begin
				best_d = d;
				best = i;
			end
		end
		return OUT_W'(best + int'(offset_cfg));
	endfunction

	function automatic logic [COLOR_W-1:0] rand_chan();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd1;
			3: return 8'd254;
			4: return 8'd128;
			default: return COLOR_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [COLOR_W-1:0] near_chan(input logic [COLOR_W-1:0] c);
		int v;
		v = int'(c) + int'($urandom_range(0, 6)) - 3;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return COLOR_W'(v);
	endfunction

	task automatic push_word(input cmd_code_t op, input int slot, input logic [COLOR_W-1:0] r,
			input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
		palette_word_t w;
		w.op = op;
		w.slot = 8'(slot);
		w.r = r;
		w.g = g;
		w.b = b;
		word_q.push_back(w);
	endtask

	task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
			input logic [OUT_W-1:0] want);
		$display("tb: mismatch %s at cycle %0d: got %0d want %0d", what, cycles, got, want);
		err_count++;
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [NUM_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_NUM_ENTRIES)
			num_cfg = val;
		else
			offset_cfg = val[7:0];
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Load words give no result, so a fixed tail follows the last expected index.
	task automatic wait_idle();
		while (word_q.size() > 0 || drv_busy || index_q.size() > 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic fill_phase(input int count);
		int n, s;
		n = active_count();
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 9) < 4) begin
				s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, n - 1);
				push_word(CMD_LOAD, s, rand_chan(), rand_chan(), rand_chan());
			end else if ($urandom_range(0, 1) == 0) begin
				s = $urandom_range(0, n - 1);
				push_word(CMD_SELECT, $urandom_range(0, 255), near_chan(pal_r[s]),
					near_chan(pal_g[s]), near_chan(pal_b[s]));
			end else begin
				push_word(CMD_SELECT, $urandom_range(0, 255), rand_chan(), rand_chan(),
					rand_chan());
			end
		end
	endtask

	always @(negedge clk) begin
		if (arst_n && !drv_busy) begin
			if (drv_gap == 0 && word_q.size() > 0) begin
				cur_word = word_q.pop_front();
				cmd <= cur_word.op;
				entry_index <= cur_word.slot;
				red <= cur_word.r;
				green <= cur_word.g;
				blue <= cur_word.b;
				in_valid <= 1'b1;
				drv_busy = 1'b1;
			end else begin
				in_valid <= 1'b0;
				if (drv_gap > 0)
					drv_gap--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			if (cur_word.op == CMD_LOAD) begin
				pal_r[cur_word.slot] = cur_word.r;
				pal_g[cur_word.slot] = cur_word.g;
				pal_b[cur_word.slot] = cur_word.b;
			end else begin
				index_q.push_back(nearest_color(cur_word.r, cur_word.g, cur_word.b));
			end
			drv_busy = 1'b0;
			if ($urandom_range(0, 39) == 0)
				drv_calm = !drv_calm;
			drv_gap = drv_calm ? 0 : $urandom_range(0, 7);
		end
	end

	always @(negedge clk) begin
		if (out_valid && rx_wait > 0) begin
			out_stall <= 1'b1;
			rx_wait--;
		end else if (out_valid) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (index_q.size() == 0) begin
				report_mismatch("unexpected color_index word", color_index, '0);
			end else begin
				want_index = index_q.pop_front();
				if (color_index !== want_index)
					report_mismatch("color_index", color_index, want_index);
			end
			if ($urandom_range(0, 39) == 0)
				rx_calm = !rx_calm;
			rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Fill the whole palette first so that no search ever reads an unloaded entry.
		for (int i = 0; i < PALETTE_DEPTH; i++) begin
			case (i)
				0: push_word(CMD_LOAD, i, 8'd0, 8'd0, 8'd0);
				1: push_word(CMD_LOAD, i, 8'd255, 8'd0, 8'd0);
				2: push_word(CMD_LOAD, i, 8'd0, 8'd255, 8'd0);
				3: push_word(CMD_LOAD, i, 8'd0, 8'd0, 8'd255);
				4, 5: push_word(CMD_LOAD, i, 8'd10, 8'd20, 8'd30);
				6: push_word(CMD_LOAD, i, 8'd100, 8'd100, 8'd100);
				7: push_word(CMD_LOAD, i, 8'd102, 8'd100, 8'd100);
				255: push_word(CMD_LOAD, i, 8'd255, 8'd255, 8'd255);
				default: push_word(CMD_LOAD, i, rand_chan(), rand_chan(), rand_chan());
			endcase
		end
		push_word(CMD_SELECT, 0, 8'd0, 8'd0, 8'd0);
		push_word(CMD_SELECT, 255, 8'd255, 8'd255, 8'd255);
		push_word(CMD_SELECT, 0, 8'd250, 8'd5, 8'd5);
		push_word(CMD_SELECT, 0, 8'd0, 8'd255, 8'd0);
		push_word(CMD_SELECT, 0, 8'd0, 8'd0, 8'd250);
		push_word(CMD_SELECT, 0, 8'd10, 8'd20, 8'd30);
		push_word(CMD_SELECT, 0, 8'd101, 8'd100, 8'd100);
		push_word(CMD_SELECT, 0, 8'd128, 8'd128, 8'd128);
		push_word(CMD_SELECT, 0, 8'd255, 8'd0, 8'd255);
		push_word(CMD_SELECT, 0, 8'd1, 8'd254, 8'd1);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_NUM_ENTRIES, NUM_W'(ph_num[p]));
			write_reg(REG_INDEX_OFFSET, NUM_W'(ph_off[p]));
			if (ph_num[p] == 256 && ph_off[p] == 255) begin
				push_word(CMD_LOAD, 255, 8'd255, 8'd255, 8'd255);
				push_word(CMD_SELECT, 0, 8'd255, 8'd255, 8'd255);
			end
			fill_phase(PHASE_WORDS);
			wait_idle();
		end

		if (err_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ----- nearest_palette_index_select_unit.f -----
+incdir+rtl
rtl/npis_pkg.sv
rtl/npis_datapath.sv
rtl/npis_ctrl.sv
rtl/nearest_palette_index_select_unit.sv
test/tb.sv
